>>> rtl/core/positional_list_engine_assert.svh
// ---------------------------------------------------------------------------
// positional_list_engine_assert.svh
// Assertion macros used by the list engine checker.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, held off during reset
`define PLE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list engine check failed");

// Next-cycle implication, held off during reset
`define PLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list engine check failed");

`endif

>>> rtl/core/ple_pkg.sv
// ---------------------------------------------------------------------------
// ple_pkg
// Shared constants, codes and types of the positional list engine.
// ---------------------------------------------------------------------------
package ple_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int ACT_W      = 3;
    localparam int POS_W      = 7;
    localparam int STAT_W     = 2;

    // Action codes
    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 3'd0,
        ACT_GET    = 3'd1,
        ACT_SET    = 3'd2,
        ACT_REMOVE = 3'd3,
        ACT_RM_VAL = 3'd4,
        ACT_FIND   = 3'd5
    } action_t;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_ABSENT = 2'd3;

    // Control broadcast to every cell of the row
    typedef struct packed {
        logic                  probe;       // latch per-cell match against probe_word
        logic [DATA_WIDTH-1:0] probe_word;
        logic [CNT_W-1:0]      count;
        logic                  search;      // mark from match chain, not from position
        logic [POS_W-1:0]      pos;
        logic [DATA_WIDTH-1:0] write_word;
        logic                  do_ins;
        logic                  do_set;
        logic                  do_rem;
    } cell_ctrl_t;

endpackage

>>> rtl/core/positional_list_engine.sv
// Sequencing: probe in the input transfer cycle, execute in the next; the
// result register is loaded at the end of the execute cycle.
// Only one item is in flight: the row of cells matches in the probe cycle
// and shifts in the execute cycle, and a new item is taken only after the last is done.
// A stalled output holds the execute cycle until the result register frees.
// Reset: asynchronous, all entries cleared to zero and length set to zero.
// ---------------------------------------------------------------------------
// positional_list_engine
// Fixed-capacity ordered list built from a row of shifting cells.
// ---------------------------------------------------------------------------
module positional_list_engine
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [ple_pkg::ACT_W-1:0]            action,
    input  logic [ple_pkg::DATA_WIDTH-1:0]       value,
    input  logic [ple_pkg::POS_W-1:0]            position,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [ple_pkg::DATA_WIDTH-1:0]       read_value,
    output logic [ple_pkg::IDX_W-1:0]            found_position,
    output logic                                 found,
    output logic [ple_pkg::STAT_W-1:0]           status,
    output logic [ple_pkg::CNT_W-1:0]            length
);

    localparam int DW    = ple_pkg::DATA_WIDTH;
    localparam int CAP   = ple_pkg::CAPACITY;
    localparam int IDX_W = ple_pkg::IDX_W;
    localparam int CNT_W = ple_pkg::CNT_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAP);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t                        state_reg, state_next;
    logic [ple_pkg::ACT_W-1:0]     act_reg;
    logic [DW-1:0]                 word_reg;
    logic [ple_pkg::POS_W-1:0]     pos_reg;
    logic [CNT_W-1:0]              count_reg, count_next;

    logic                          out_valid_reg, out_valid_next;
    logic [DW-1:0]                 rd_reg, rd_next;
    logic [IDX_W-1:0]              fpos_reg, fpos_next;
    logic                          found_reg, found_next;
    logic [ple_pkg::STAT_W-1:0]    status_reg, status_next;

    logic                          accept;
    logic                          done;
    logic                          search;
    logic                          ok_ins, ok_set, ok_rem;
    logic                          hit_any;
    logic [DW-1:0]                 sel_data;
    logic [IDX_W-1:0]              sel_idx;

    ple_pkg::cell_ctrl_t           ctrl;

    logic [DW-1:0]                 entry_w [CAP];
    logic [CAP:0]                  seen_w;
    logic [CAP:0]                  mark_w;
    logic [CAP-1:0]                target_w;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign done     = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);
    assign search   = (act_reg == ple_pkg::ACT_RM_VAL) || (act_reg == ple_pkg::ACT_FIND);
    assign hit_any  = seen_w[CAP];

    // Cell row
    assign seen_w[0] = 1'b0;
    assign mark_w[0] = 1'b0;

    for (genvar g = 0; g < CAP; g++)
    begin : g_cell
        logic [DW-1:0] left_d;
        logic [DW-1:0] right_d;
        if (g == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = entry_w[g-1];
        end
        if (g == CAP - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = entry_w[g+1];
        end

        ple_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_idx   (IDX_W'(g)),
            .ctrl       (ctrl),
            .left_data  (left_d),
            .right_data (right_d),
            .seen_in    (seen_w[g]),
            .mark_in    (mark_w[g]),
            .entry      (entry_w[g]),
            .seen_out   (seen_w[g+1]),
            .mark_out   (mark_w[g+1]),
            .target     (target_w[g])
        );
    end

    // Selected slot: index and contents of the single target cell
    always_comb
    begin
        sel_data = '0;
        sel_idx  = '0;
        for (int i = 0; i < CAP; i++)
        begin
            if (target_w[i])
            begin
                sel_data = sel_data | entry_w[i];
                sel_idx  = sel_idx | IDX_W'(i);
            end
        end
    end

    // Decode action, status and result fields
    always_comb
    begin
        ok_ins      = 1'b0;
        ok_set      = 1'b0;
        ok_rem      = 1'b0;
        rd_next     = '0;
        fpos_next   = '0;
        found_next  = 1'b0;
        status_next = ple_pkg::ST_OK;
        unique case (act_reg)
            ple_pkg::ACT_INSERT:
            begin
                if (count_reg == CAP_CNT)
                begin
                    status_next = ple_pkg::ST_FULL;
                end
                else if (CNT_W'(pos_reg) > count_reg)
                begin
                    status_next = ple_pkg::ST_RANGE;
                end
                else
                begin
                    ok_ins = 1'b1;
                end
            end
            ple_pkg::ACT_GET:
            begin
                if (CNT_W'(pos_reg) < count_reg)
                begin
                    rd_next = sel_data;
                end
                else
                begin
                    status_next = ple_pkg::ST_RANGE;
                end
            end
            ple_pkg::ACT_SET:
            begin
                if (CNT_W'(pos_reg) < count_reg)
                begin
                    ok_set = 1'b1;
                end
                else
                begin
                    status_next = ple_pkg::ST_RANGE;
                end
            end
            ple_pkg::ACT_REMOVE:
            begin
                if (CNT_W'(pos_reg) < count_reg)
                begin
                    ok_rem = 1'b1;
                end
                else
                begin
                    status_next = ple_pkg::ST_RANGE;
                end
            end
            ple_pkg::ACT_RM_VAL, ple_pkg::ACT_FIND:
            begin
                if (hit_any)
                begin
                    found_next = 1'b1;
                    fpos_next  = sel_idx;
                    ok_rem     = (act_reg == ple_pkg::ACT_RM_VAL);
                end
                else
                begin
                    status_next = ple_pkg::ST_ABSENT;
                end
            end
            default:
            begin
                status_next = ple_pkg::ST_OK;
            end
        endcase
    end

    // Broadcast to the cells; updates land only when the result is registered
    always_comb
    begin
        ctrl.probe      = accept;
        ctrl.probe_word = value;
        ctrl.count      = count_reg;
        ctrl.search     = search;
        ctrl.pos        = pos_reg;
        ctrl.write_word = word_reg;
        ctrl.do_ins     = done && ok_ins;
        ctrl.do_set     = done && ok_set;
        ctrl.do_rem     = done && ok_rem;
    end

    // Length and sequencing
    always_comb
    begin
        count_next     = count_reg;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (done)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    if (ok_ins)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else if (ok_rem)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Command and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= action;
            word_reg <= value;
            pos_reg  <= position;
        end
        if (done)
        begin
            rd_reg     <= rd_next;
            fpos_reg   <= fpos_next;
            found_reg  <= found_next;
            status_reg <= status_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_value     = rd_reg;
    assign found_position = fpos_reg;
    assign found          = found_reg;
    assign status         = status_reg;
    assign length         = count_reg;

endmodule

>>> rtl/core/ple_cell.sv
// ---------------------------------------------------------------------------
// ple_cell
// One list slot: holds an entry, matches it against a probe word and
// shifts towards either neighbour on insert or removal.
// ---------------------------------------------------------------------------
module ple_cell
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [ple_pkg::IDX_W-1:0]        cell_idx,
    input  ple_pkg::cell_ctrl_t              ctrl,
    input  logic [ple_pkg::DATA_WIDTH-1:0]   left_data,
    input  logic [ple_pkg::DATA_WIDTH-1:0]   right_data,
    input  logic                             seen_in,
    input  logic                             mark_in,
    output logic [ple_pkg::DATA_WIDTH-1:0]   entry,
    output logic                             seen_out,
    output logic                             mark_out,
    output logic                             target
);

    logic [ple_pkg::DATA_WIDTH-1:0] entry_reg;
    logic [ple_pkg::DATA_WIDTH-1:0] entry_next;
    logic                           hit_reg;
    logic                           hit_next;
    logic                           in_use;
    logic                           pos_mark;

    assign in_use = {1'b0, cell_idx} < ctrl.count;

    // Match latched at the probe so the chain below starts from a flop
    always_comb
    begin
        hit_next = hit_reg;
        if (ctrl.probe)
        begin
            hit_next = in_use && (entry_reg == ctrl.probe_word);
        end
    end

    // Match chain: seen means some cell at or before this one matched
    assign seen_out = seen_in | hit_reg;
    assign pos_mark = ple_pkg::POS_W'(cell_idx) >= ctrl.pos;
    assign mark_out = ctrl.search ? seen_out : pos_mark;
    assign target   = mark_out & ~mark_in;

    // Entry update
    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.do_ins && target)
        begin
            entry_next = ctrl.write_word;
        end
        else if (ctrl.do_ins && mark_out)
        begin
            entry_next = left_data;
        end
        else if (ctrl.do_set && target)
        begin
            entry_next = ctrl.write_word;
        end
        else if (ctrl.do_rem && mark_out)
        begin
            entry_next = right_data;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    // Entries reset to zero: slots past the length must read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            entry_reg <= entry_next;
            hit_reg   <= hit_next;
        end
    end

    assign entry = entry_reg;

endmodule

>>> rtl/core/ple_checker.sv
// ---------------------------------------------------------------------------
// ple_checker
// Port-level checks of the list engine, bound onto the top level.
// ---------------------------------------------------------------------------
`include "positional_list_engine_assert.svh"

module ple_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic [ple_pkg::DATA_WIDTH-1:0]       read_value,
    input  logic [ple_pkg::IDX_W-1:0]            found_position,
    input  logic                                 found,
    input  logic [ple_pkg::STAT_W-1:0]           status,
    input  logic [ple_pkg::CNT_W-1:0]            length
);

    // A held result keeps its read value, status and length
    `PLE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(read_value) && $stable(status) && $stable(length))

    // One item in flight: a transfer in closes the input for the next cycle
    `PLE_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall)

    // A full report only when the list is at capacity
    `PLE_ASSERT_SAME(a_full_len, clk, rst_n, out_valid && (status == ple_pkg::ST_FULL), length == ple_pkg::CNT_W'(ple_pkg::CAPACITY))

    // A match is always a successful result
    `PLE_ASSERT_SAME(a_found_ok, clk, rst_n, out_valid && found, status == ple_pkg::ST_OK)

    // Length never exceeds capacity while a result is offered
    `PLE_ASSERT_SAME(a_len_cap, clk, rst_n, out_valid, length <= ple_pkg::CNT_W'(ple_pkg::CAPACITY))

endmodule

bind positional_list_engine ple_checker u_ple_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_value     (read_value),
    .found_position (found_position),
    .found          (found),
    .status         (status),
    .length         (length)
);

>>> bench/tb_positional_list_engine.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_positional_list_engine
// Self-checking bench for the fixed-capacity list engine. A shadow copy of
// the list predicts each result. A short directed run comes first, then
// random sequences that grow, churn and drain the list. Both sides idle in
// bursts, and the receiver holds off once for a long stretch.
// ---------------------------------------------------------------------------
module tb_positional_list_engine;

    localparam int CAPACITY   = ple_pkg::CAPACITY;
    localparam int DATA_WIDTH = ple_pkg::DATA_WIDTH;
    localparam int IDX_W      = ple_pkg::IDX_W;
    localparam int CNT_W      = ple_pkg::CNT_W;
    localparam int ACT_W      = ple_pkg::ACT_W;
    localparam int POS_W      = ple_pkg::POS_W;
    localparam int STAT_W     = ple_pkg::STAT_W;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 80;
    localparam int SEGMENTS      = 6;
    localparam int SEGMENT_ITEMS = 150;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PRINT_LIMIT   = 40;
    localparam int POS_MAX       = (1 << POS_W) - 1;

    // action codes the block leaves unused
    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    // operation mixes for the random part
    localparam int MIX_GROW   = 0;
    localparam int MIX_EVEN   = 1;
    localparam int MIX_SHRINK = 2;

    // cumulative percentages: insert, get, set, remove, remove value, find
    localparam logic [5:0][7:0] GROW_CUT   = {8'd98, 8'd90, 8'd84, 8'd76, 8'd68, 8'd60};
    localparam logic [5:0][7:0] EVEN_CUT   = {8'd96, 8'd80, 8'd70, 8'd55, 8'd45, 8'd30};
    localparam logic [5:0][7:0] SHRINK_CUT = {8'd97, 8'd82, 8'd65, 8'd33, 8'd25, 8'd15};

    // recurring words, so that duplicates and first-match cases turn up
    localparam logic [7:0][DATA_WIDTH-1:0] WORD_POOL = {
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
        32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h0000_FFFF
    };

    typedef struct packed {
        logic [DATA_WIDTH-1:0] read_value;
        logic [IDX_W-1:0]      found_position;
        logic                  found;
        logic [STAT_W-1:0]     status;
        logic [CNT_W-1:0]      length;
    } list_result_t;

    // Shadow of the list contents plus the results still owed by the block
    class list_shadow;
        logic [DATA_WIDTH-1:0] words [CAPACITY];
        int unsigned           entry_len;
        list_result_t          owed_results [$];
        int unsigned           mismatches;
        int unsigned           checked;
        int unsigned           status_seen [4];
        int unsigned           hits;
        int unsigned           peak_len;

        function void clear();
            foreach (words[i])
                words[i] = '0;
            foreach (status_seen[i])
                status_seen[i] = 0;
            entry_len  = 0;
            mismatches = 0;
            checked    = 0;
            hits       = 0;
            peak_len   = 0;
            owed_results.delete();
        endfunction

        function int unsigned pending();
            return owed_results.size();
        endfunction

        // close the gap at idx and clear the freed top slot
        function void drop_entry(int unsigned idx);
            int unsigned i;
            for (i = idx; i + 1 < entry_len; i++)
                words[i] = words[i + 1];
            words[entry_len - 1] = '0;
            entry_len--;
        endfunction

        // apply one accepted operation and queue the result it must give
        function void note_operation(logic [ACT_W-1:0] act, logic [DATA_WIDTH-1:0] word,
                                     logic [POS_W-1:0] pos);
            list_result_t res;
            int unsigned  i;
            int unsigned  match_at;
            res        = '0;
            res.status = ple_pkg::ST_OK;
            case (act)
                ple_pkg::ACT_INSERT:
                begin
                    // fullness is tested before the position
                    if (entry_len >= CAPACITY)
                        res.status = ple_pkg::ST_FULL;
                    else if (pos > entry_len)
                        res.status = ple_pkg::ST_RANGE;
                    else
                    begin
                        for (i = entry_len; i > pos; i--)
                            words[i] = words[i - 1];
                        words[pos] = word;
                        entry_len++;
                    end
                end
                ple_pkg::ACT_GET:
                begin
                    if (pos < entry_len)
                        res.read_value = words[pos];
                    else
                        res.status = ple_pkg::ST_RANGE;
                end
                ple_pkg::ACT_SET:
                begin
                    if (pos < entry_len)
                        words[pos] = word;
                    else
                        res.status = ple_pkg::ST_RANGE;
                end
                ple_pkg::ACT_REMOVE:
                begin
                    if (pos < entry_len)
                        drop_entry(pos);
                    else
                        res.status = ple_pkg::ST_RANGE;
                end
                ple_pkg::ACT_RM_VAL, ple_pkg::ACT_FIND:
                begin
                    // scan downwards so the lowest match wins
                    match_at = entry_len;
                    for (i = entry_len; i > 0; i--)
                        if (words[i - 1] == word)
                            match_at = i - 1;
                    if (match_at < entry_len)
                    begin
                        res.found          = 1'b1;
                        res.found_position = IDX_W'(match_at);
                        hits++;
                        if (act == ple_pkg::ACT_RM_VAL)
                            drop_entry(match_at);
                    end
                    else
                        res.status = ple_pkg::ST_ABSENT;
                end
                default:
                begin
                    // unused codes leave everything alone
                end
            endcase
            res.length = CNT_W'(entry_len);
            status_seen[res.status]++;
            if (entry_len > peak_len)
                peak_len = entry_len;
            owed_results.push_back(res);
        endfunction

        task report_mismatch(string msg);
            if (mismatches < PRINT_LIMIT)
                $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        // compare one result transfer with the oldest owed result
        task check_result(list_result_t got);
            list_result_t want;
            if (owed_results.size() == 0)
            begin
                report_mismatch($sformatf("result with none owed: status %0d length %0d",
                                          got.status, got.length));
                return;
            end
            want = owed_results.pop_front();
            checked++;
            if (got.read_value !== want.read_value)
                report_mismatch($sformatf("result %0d read_value %h, want %h",
                                          checked, got.read_value, want.read_value));
            if (got.found_position !== want.found_position)
                report_mismatch($sformatf("result %0d found_position %0d, want %0d",
                                          checked, got.found_position, want.found_position));
            if (got.found !== want.found)
                report_mismatch($sformatf("result %0d found %b, want %b",
                                          checked, got.found, want.found));
            if (got.status !== want.status)
                report_mismatch($sformatf("result %0d status %0d, want %0d",
                                          checked, got.status, want.status));
            if (got.length !== want.length)
                report_mismatch($sformatf("result %0d length %0d, want %0d",
                                          checked, got.length, want.length));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [ACT_W-1:0]      action    = '0;
    logic [DATA_WIDTH-1:0] value     = '0;
    logic [POS_W-1:0]      position  = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [DATA_WIDTH-1:0] read_value;
    logic [IDX_W-1:0]      found_position;
    logic                  found;
    logic [STAT_W-1:0]     status;
    logic [CNT_W-1:0]      length;

    list_shadow  shadow;
    bit          idling       = 1'b1;
    bit          hold_request = 1'b0;
    int unsigned cycle_count;

    positional_list_engine i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .value          (value),
        .position       (position),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .read_value     (read_value),
        .found_position (found_position),
        .found          (found),
        .status         (status),
        .length         (length)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Sample both channels at the edge; operations are noted before results
    always @(posedge clk)
    begin
        list_result_t seen;
        if (rst_n && in_valid && !in_stall)
            shadow.note_operation(action, value, position);
        if (rst_n && out_valid && !out_stall)
        begin
            seen.read_value     = read_value;
            seen.found_position = found_position;
            seen.found          = found;
            seen.status         = status;
            seen.length         = length;
            shadow.check_result(seen);
        end
    end

    // Receiver: random stall bursts, and one long hold-off on request
    initial
    begin : receiver
        int unsigned stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            else if (idling && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 9);
            out_stall <= (stall_left > 0);
        end
    end

    // Offer one operation, with an optional idle burst first; returns once taken
    task automatic send_item(input logic [ACT_W-1:0] act, input logic [DATA_WIDTH-1:0] word,
                             input logic [POS_W-1:0] pos);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        value    <= word;
        position <= pos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Random operation shaped by the mix and by the current list length
    task automatic send_random(input int mix);
        logic [ACT_W-1:0]      act;
        logic [DATA_WIDTH-1:0] word;
        logic [POS_W-1:0]      pos;
        logic [5:0][7:0]       cut;
        int unsigned           roll;
        int unsigned           len;
        len  = shadow.entry_len;
        cut  = (mix == MIX_GROW) ? GROW_CUT : (mix == MIX_SHRINK) ? SHRINK_CUT : EVEN_CUT;
        roll = $urandom_range(0, 99);
        if (roll < cut[0])
            act = ple_pkg::ACT_INSERT;
        else if (roll < cut[1])
            act = ple_pkg::ACT_GET;
        else if (roll < cut[2])
            act = ple_pkg::ACT_SET;
        else if (roll < cut[3])
            act = ple_pkg::ACT_REMOVE;
        else if (roll < cut[4])
            act = ple_pkg::ACT_RM_VAL;
        else if (roll < cut[5])
            act = ple_pkg::ACT_FIND;
        else
            act = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;

        // mostly legal positions, some just past the end, a few anywhere
        roll = $urandom_range(0, 9);
        if (roll < 8)
        begin
            if (act == ple_pkg::ACT_INSERT)
                pos = POS_W'($urandom_range(0, len));
            else
                pos = (len > 0) ? POS_W'($urandom_range(0, len - 1)) : '0;
        end
        else if (roll == 8)
            pos = POS_W'($urandom_range(len, CAPACITY));
        else
            pos = POS_W'($urandom_range(0, POS_MAX));

        // words from the pool, copied from the list, or fully random
        roll = $urandom_range(0, 9);
        if (roll < 3)
            word = WORD_POOL[$urandom_range(0, 7)];
        else if (roll < 6 && len > 0)
            word = shadow.words[$urandom_range(0, len - 1)];
        else
            word = $urandom;
        send_item(act, word, pos);
    endtask

    // Stimulus and end of run
    initial
    begin : stimulus
        int seg;
        int n;
        shadow = new;
        shadow.clear();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: every access is out of range, every search misses
        send_item(ple_pkg::ACT_GET,    32'h0000_0000, 7'd0);
        send_item(ple_pkg::ACT_REMOVE, 32'h0000_0000, 7'd0);
        send_item(ple_pkg::ACT_FIND,   32'h0000_0000, 7'd0);
        send_item(ple_pkg::ACT_RM_VAL, 32'h0000_0000, 7'd0);
        send_item(ple_pkg::ACT_INSERT, 32'h0000_0005, 7'd1);
        // front, front, append and middle inserts
        send_item(ple_pkg::ACT_INSERT, 32'hFFFF_FFFF, 7'd0);
        send_item(ple_pkg::ACT_INSERT, 32'h0000_0000, 7'd0);
        send_item(ple_pkg::ACT_INSERT, 32'hA5A5_5A5A, 7'd2);
        send_item(ple_pkg::ACT_INSERT, 32'h1234_5678, 7'd1);
        // reads at both ends and past the end, then writes in and past range
        send_item(ple_pkg::ACT_GET,    32'h0000_0000, 7'd3);
        send_item(ple_pkg::ACT_GET,    32'h0000_0000, 7'd0);
        send_item(ple_pkg::ACT_GET,    32'h0000_0000, 7'd4);
        send_item(ple_pkg::ACT_GET,    32'h0000_0000, 7'd127);
        send_item(ple_pkg::ACT_SET,    32'h8000_0001, 7'd1);
        send_item(ple_pkg::ACT_SET,    32'hDEAD_BEEF, 7'd64);
        // duplicate word: the lowest position must be reported
        send_item(ple_pkg::ACT_FIND,   32'hFFFF_FFFF, 7'd0);
        send_item(ple_pkg::ACT_INSERT, 32'hFFFF_FFFF, 7'd0);
        send_item(ple_pkg::ACT_FIND,   32'hFFFF_FFFF, 7'd0);
        send_item(ple_pkg::ACT_RM_VAL, 32'hFFFF_FFFF, 7'd0);
        send_item(ple_pkg::ACT_FIND,   32'h0BAD_F00D, 7'd0);
        send_item(ple_pkg::ACT_REMOVE, 32'h0000_0000, 7'd3);
        send_item(ple_pkg::ACT_REMOVE, 32'h0000_0000, 7'd0);
        // unused codes, then an insert far past the end
        send_item(ACT_SPARE_LO,        32'hFFFF_FFFF, 7'd127);
        send_item(ACT_SPARE_HI,        32'h0000_0000, 7'd0);
        send_item(ple_pkg::ACT_INSERT, 32'h0F0F_0F0F, 7'd64);

        // random segments: grow to full, churn, drain, refill, then churn twice
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            idling = (seg != 2) && (seg != SEGMENTS - 1);
            if (seg == 1)
                hold_request = 1'b1;
            for (n = 0; n < SEGMENT_ITEMS; n++)
                send_random((seg == 0 || seg == 3) ? MIX_GROW :
                            (seg == 2) ? MIX_SHRINK : MIX_EVEN);
        end
        in_valid <= 1'b0;

        while (shadow.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d results: %0d ok, %0d out of range, %0d full, %0d not found",
                 shadow.checked, shadow.status_seen[ple_pkg::ST_OK],
                 shadow.status_seen[ple_pkg::ST_RANGE],
                 shadow.status_seen[ple_pkg::ST_FULL],
                 shadow.status_seen[ple_pkg::ST_ABSENT]);
        $display("longest list %0d entries, %0d search hits, %0d mismatches",
                 shadow.peak_len, shadow.hits, shadow.mismatches);
        if (shadow.mismatches == 0 && shadow.pending() == 0)
            $display("tb_positional_list_engine OK");
        else
            $display("tb_positional_list_engine NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[%0t] timeout after %0d cycles, %0d results outstanding",
                 $time, cycle_count, shadow.pending());
        $display("tb_positional_list_engine NOT OK");
        $finish;
    end

endmodule
